@@ hw/rtl/pmms_pkg.sv @@
package pmms_pkg;

  // Fixed widths of the transaction fields
  localparam int MODE_BITS  = 2;
  localparam int FIELD_BITS = 48;
  localparam int SW_BITS    = 2;
  localparam int MIN_BITS   = 16;
  localparam int SLOW_BITS  = 8;
  localparam int CFG_IDX_BITS = 1;
  localparam int CFG_DATA_BITS = 16;

  // Event kinds carried by in_mode; code 3 is unused and changes nothing
  typedef enum logic [MODE_BITS-1:0] {
    EV_EVAL    = 2'd0,
    EV_MEM_ISS = 2'd1,
    EV_PIM_ISS = 2'd2
  } event_t;

  // Switch report codes
  typedef enum logic [SW_BITS-1:0] {
    SW_NONE   = 2'd0,
    SW_TO_MEM = 2'd1,
    SW_TO_PIM = 2'd2
  } switch_t;

  // Configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_MIN_PIM  = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] REG_SLOWDOWN = 1'b1;

  localparam logic [MIN_BITS-1:0]  MIN_PIM_RST  = 16'd8;
  localparam logic [SLOW_BITS-1:0] SLOWDOWN_RST = 8'd1;

endpackage

@@ hw/rtl/pim_mem_mode_switch_policy.sv @@
// Pipeline: an accepted transaction is captured in the input register, and its result
//   is registered once the result slot is free. One transaction per cycle unless
//   out_ready stalls; the decision logic (subtract, 48 by 8 bit multiply, saturating
//   add) sits in one stage between input and result registers.
// Reset: synchronous, active low; clears both stages, the mode state and restores the
//   configuration registers to min_pim_requests = 8, slowdown_factor = 1.
module pim_mem_mode_switch_policy #(
  parameter int CYCLE_BITS = 48,
  parameter int COUNT_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration write port
  input  logic                              cfg_wr_en,
  input  logic [pmms_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [pmms_pkg::CFG_DATA_BITS-1:0] cfg_wdata,
  // event input channel
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [pmms_pkg::MODE_BITS-1:0]    in_mode,
  input  logic [pmms_pkg::FIELD_BITS-1:0]   in_cycle,
  input  logic                              in_have_mem,
  input  logic                              in_have_pim,
  // result channel
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_pim_active,
  output logic [pmms_pkg::SW_BITS-1:0]      out_switch_event,
  output logic [pmms_pkg::FIELD_BITS-1:0]   out_closed_batch_time,
  output logic                              out_wasted_valid,
  output logic [pmms_pkg::FIELD_BITS-1:0]   out_wasted_cycles
);
  import pmms_pkg::*;

  localparam int PROD_BITS = CYCLE_BITS + SLOW_BITS;
  localparam int CMP_BITS  = (COUNT_BITS > MIN_BITS) ? COUNT_BITS : MIN_BITS;

  // Configuration registers
  logic [MIN_BITS-1:0]  min_pim_r;
  logic [SLOW_BITS-1:0] slowdown_r;

  // Input register stage
  logic                  s1_valid_r;
  logic [MODE_BITS-1:0]  s1_mode_r;
  logic [CYCLE_BITS-1:0] s1_cycle_r;
  logic                  s1_mem_r;
  logic                  s1_pim_r;

  // Policy state
  logic                  pim_act_r,   pim_act_nxt;
  logic [COUNT_BITS-1:0] pim_cnt_r,   pim_cnt_nxt;
  logic [CYCLE_BITS-1:0] pim_beg_r,   pim_beg_nxt;
  logic [CYCLE_BITS-1:0] pim_len_r,   pim_len_nxt;
  logic [CYCLE_BITS-1:0] mem_dl_r,    mem_dl_nxt;
  logic [CYCLE_BITS-1:0] mem_beg_r,   mem_beg_nxt;

  // Result register stage
  logic                  out_valid_r;
  logic                  o_act_r,    o_act_nxt;
  logic [SW_BITS-1:0]    o_sw_r,     o_sw_nxt;
  logic [CYCLE_BITS-1:0] o_closed_r, o_closed_nxt;
  logic                  o_wv_r,     o_wv_nxt;
  logic [CYCLE_BITS-1:0] o_wasted_r, o_wasted_nxt;

  // Handshake: the input register drains into the result register when the
  // result slot is free or being taken this cycle.
  logic advance;
  assign advance  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || advance;

  // Datapath pieces
  logic [CMP_BITS-1:0]   cnt_w, min_w;
  logic [CYCLE_BITS-1:0] pim_dur, mem_dur, len_eval, prod_sat, deadline;
  logic [PROD_BITS-1:0]  prod_full;
  logic [CYCLE_BITS:0]   dl_sum;
  logic                  cnt_le_min, cnt_ge_min;

  assign cnt_w      = CMP_BITS'(pim_cnt_r);
  assign min_w      = CMP_BITS'(min_pim_r);
  assign cnt_le_min = (cnt_w <= min_w);
  assign cnt_ge_min = (cnt_w >= min_w);

  // Batch durations wrap modulo 2^CYCLE_BITS, also against a zero begin time
  assign pim_dur  = s1_cycle_r - pim_beg_r;
  assign mem_dur  = s1_cycle_r - mem_beg_r;
  // Batch length is only refreshed while the minimum count has not been passed
  assign len_eval = cnt_le_min ? pim_dur : pim_len_r;

  // Deadline = cycle + slowdown * length, product and sum both saturate
  assign prod_full = PROD_BITS'(len_eval) * PROD_BITS'(slowdown_r);
  assign prod_sat  = (|prod_full[PROD_BITS-1:CYCLE_BITS]) ? '1
                                                           : prod_full[CYCLE_BITS-1:0];
  assign dl_sum    = {1'b0, s1_cycle_r} + {1'b0, prod_sat};
  assign deadline  = dl_sum[CYCLE_BITS] ? '1 : dl_sum[CYCLE_BITS-1:0];

  always_comb begin
    pim_act_nxt  = pim_act_r;
    pim_cnt_nxt  = pim_cnt_r;
    pim_beg_nxt  = pim_beg_r;
    pim_len_nxt  = pim_len_r;
    mem_dl_nxt   = mem_dl_r;
    mem_beg_nxt  = mem_beg_r;
    o_sw_nxt     = SW_NONE;
    o_closed_nxt = '0;
    o_wv_nxt     = 1'b0;
    o_wasted_nxt = '0;
    case (s1_mode_r)
      EV_EVAL: begin
        if (pim_act_r) begin
          pim_len_nxt = len_eval;
          // leave PIM mode once enough PIMs ran or PIM queue dried up, if memory work waits
          if ((cnt_ge_min || !s1_pim_r) && s1_mem_r) begin
            o_closed_nxt = pim_dur;
            mem_dl_nxt   = deadline;
            pim_cnt_nxt  = '0;
            pim_beg_nxt  = '0;
            pim_len_nxt  = '0;
            pim_act_nxt  = 1'b0;
            o_sw_nxt     = SW_TO_MEM;
          end
        end else begin
          // back to PIM once the memory budget ran out or memory work is gone, if PIM work waits
          if (((s1_cycle_r > mem_dl_r) || !s1_mem_r) && s1_pim_r) begin
            pim_act_nxt  = 1'b1;
            o_sw_nxt     = SW_TO_PIM;
            o_closed_nxt = mem_dur;
            mem_beg_nxt  = '0;
            if (s1_cycle_r < mem_dl_r) begin
              o_wv_nxt     = 1'b1;
              o_wasted_nxt = mem_dl_r - s1_cycle_r;
            end
          end
        end
      end
      EV_MEM_ISS: begin
        if (mem_beg_r == '0) begin
          mem_beg_nxt = s1_cycle_r;
        end
      end
      EV_PIM_ISS: begin
        if (pim_beg_r == '0) begin
          pim_beg_nxt = s1_cycle_r;
        end
        if (pim_cnt_r != '1) begin
          pim_cnt_nxt = pim_cnt_r + 1'b1;
        end
      end
      default: begin
        // unused code: report current mode only
      end
    endcase
    o_act_nxt = pim_act_nxt;
  end

  // Control, state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_pim_r   <= MIN_PIM_RST;
      slowdown_r  <= SLOWDOWN_RST;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      pim_act_r   <= 1'b0;
      pim_cnt_r   <= '0;
      pim_beg_r   <= '0;
      pim_len_r   <= '0;
      mem_dl_r    <= '0;
      mem_beg_r   <= '0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_MIN_PIM:  min_pim_r  <= cfg_wdata[MIN_BITS-1:0];
          REG_SLOWDOWN: slowdown_r <= cfg_wdata[SLOW_BITS-1:0];
          default: begin
          end
        endcase
      end
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        pim_act_r   <= pim_act_nxt;
        pim_cnt_r   <= pim_cnt_nxt;
        pim_beg_r   <= pim_beg_nxt;
        pim_len_r   <= pim_len_nxt;
        mem_dl_r    <= mem_dl_nxt;
        mem_beg_r   <= mem_beg_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_mode_r  <= in_mode;
      s1_cycle_r <= CYCLE_BITS'(in_cycle);
      s1_mem_r   <= in_have_mem;
      s1_pim_r   <= in_have_pim;
    end
    if (advance) begin
      o_act_r    <= o_act_nxt;
      o_sw_r     <= o_sw_nxt;
      o_closed_r <= o_closed_nxt;
      o_wv_r     <= o_wv_nxt;
      o_wasted_r <= o_wasted_nxt;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_pim_active        = o_act_r;
  assign out_switch_event      = o_sw_r;
  assign out_closed_batch_time = FIELD_BITS'(o_closed_r);
  assign out_wasted_valid      = o_wv_r;
  assign out_wasted_cycles     = FIELD_BITS'(o_wasted_r);

endmodule

@@ hw/rtl/pmms_checker.sv @@
module pmms_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic                            out_pim_active,
  input logic [pmms_pkg::SW_BITS-1:0]    out_switch_event,
  input logic [pmms_pkg::FIELD_BITS-1:0] out_closed_batch_time,
  input logic                            out_wasted_valid,
  input logic [pmms_pkg::FIELD_BITS-1:0] out_wasted_cycles
);
  import pmms_pkg::*;

  // A switch to memory mode leaves the channel out of PIM mode
  a_to_mem_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_switch_event == SW_TO_MEM |-> !out_pim_active)
    else $error("switch to memory mode but pim_active set");

  // A switch to PIM mode leaves the channel in PIM mode
  a_to_pim_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_switch_event == SW_TO_PIM |-> out_pim_active)
    else $error("switch to PIM mode but pim_active clear");

  // Without a switch nothing is closed and nothing is wasted
  a_no_switch_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_switch_event == SW_NONE |->
      out_closed_batch_time == '0 && !out_wasted_valid)
    else $error("batch time or waste reported without a switch");

  // Waste only on an early switch back to PIM mode
  a_waste_on_pim_switch: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_wasted_valid |->
      out_switch_event == SW_TO_PIM && out_wasted_cycles != '0)
    else $error("wasted cycles outside an early PIM switch");

  // A stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_switch_event) &&
      $stable(out_closed_batch_time) && $stable(out_wasted_cycles))
    else $error("result transaction changed while stalled");

endmodule

bind pim_mem_mode_switch_policy pmms_checker u_pmms_checker (
  .clk                   (clk),
  .rst_n                 (rst_n),
  .out_valid             (out_valid),
  .out_ready             (out_ready),
  .out_pim_active        (out_pim_active),
  .out_switch_event      (out_switch_event),
  .out_closed_batch_time (out_closed_batch_time),
  .out_wasted_valid      (out_wasted_valid),
  .out_wasted_cycles     (out_wasted_cycles)
);

@@ sim/tb_pim_mem_mode_switch_policy.sv @@
module tb_pim_mem_mode_switch_policy;
  import pmms_pkg::*;

  localparam logic [FIELD_BITS-1:0] CYC_MAX = '1;
  // Event code 3 has no enum member; the block must treat it as a no-op
  localparam logic [MODE_BITS-1:0] EV_UNUSED = 2'd3;
  // Length of the long receiver hold-off, in cycles
  localparam int LONG_HOLD = 300;
  // Mismatch reports printed before going quiet
  localparam int MAX_REPORTS = 40;

  // One result transaction as the block reports it
  typedef struct {
    logic                  pim_active;
    switch_t               sw;
    logic [FIELD_BITS-1:0] closed;
    logic                  wasted_valid;
    logic [FIELD_BITS-1:0] wasted;
  } mode_report_t;

  // Scoreboard: tracks the channel mode state, predicts one report per
  // accepted event and compares arriving reports in order.
  class switch_scoreboard;
    logic [MIN_BITS-1:0]   min_pim;
    logic [SLOW_BITS-1:0]  slowdown;
    logic                  in_pim_side;
    logic [MIN_BITS-1:0]   pim_count;
    logic [FIELD_BITS-1:0] pim_begin;
    logic [FIELD_BITS-1:0] pim_len;
    logic [FIELD_BITS-1:0] deadline;
    logic [FIELD_BITS-1:0] mem_begin;
    mode_report_t          expected_reports[$];
    int n_checked, n_errors, n_to_mem, n_to_pim, n_wasted;

    function new();
      min_pim     = MIN_PIM_RST;
      slowdown    = SLOWDOWN_RST;
      in_pim_side = 1'b0;
      pim_count   = '0;
      pim_begin   = '0;
      pim_len     = '0;
      deadline    = '0;
      mem_begin   = '0;
    endfunction

    function void set_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
      if (idx == REG_MIN_PIM) min_pim = val[MIN_BITS-1:0];
      else if (idx == REG_SLOWDOWN) slowdown = val[SLOW_BITS-1:0];
    endfunction

    // now + slowdown * len, product and sum both clamp at all ones
    function logic [FIELD_BITS-1:0] budget_end(logic [FIELD_BITS-1:0] now,
                                               logic [FIELD_BITS-1:0] len);
      logic [FIELD_BITS+SLOW_BITS-1:0] prod;
      logic [FIELD_BITS:0]             sum;
      prod = slowdown * len;
      if (prod > {{SLOW_BITS{1'b0}}, CYC_MAX}) prod = {{SLOW_BITS{1'b0}}, CYC_MAX};
      sum = now + prod[FIELD_BITS-1:0];
      return sum[FIELD_BITS] ? CYC_MAX : sum[FIELD_BITS-1:0];
    endfunction

    function void add_event(logic [MODE_BITS-1:0] kind, logic [FIELD_BITS-1:0] now,
                            logic mem, logic pim);
      mode_report_t r;
      r.sw           = SW_NONE;
      r.closed       = '0;
      r.wasted_valid = 1'b0;
      r.wasted       = '0;
      case (kind)
        EV_EVAL: begin
          if (in_pim_side) begin
            if (pim_count <= min_pim) pim_len = now - pim_begin;
            if ((pim_count >= min_pim || !pim) && mem) begin
              r.closed    = now - pim_begin;
              deadline    = budget_end(now, pim_len);
              pim_count   = '0;
              pim_begin   = '0;
              pim_len     = '0;
              in_pim_side = 1'b0;
              r.sw        = SW_TO_MEM;
              n_to_mem++;
            end
          end else if ((now > deadline || !mem) && pim) begin
            in_pim_side = 1'b1;
            r.sw        = SW_TO_PIM;
            r.closed    = now - mem_begin;
            mem_begin   = '0;
            n_to_pim++;
            if (now < deadline) begin
              r.wasted_valid = 1'b1;
              r.wasted       = deadline - now;
              n_wasted++;
            end
          end
        end
        EV_MEM_ISS: begin
          if (mem_begin == '0) mem_begin = now;
        end
        EV_PIM_ISS: begin
          if (pim_begin == '0) pim_begin = now;
          if (pim_count != '1) pim_count++;
        end
        default: ;
      endcase
      r.pim_active = in_pim_side;
      expected_reports = {expected_reports, r};
    endfunction

    function void compare_field(string name, logic [FIELD_BITS-1:0] want,
                                logic [FIELD_BITS-1:0] got);
      if (got !== want) begin
        n_errors++;
        if (n_errors <= MAX_REPORTS)
          $error("%s: expected %0h, got %0h", name, want, got);
      end
    endfunction

    function void check_report(mode_report_t got);
      mode_report_t want;
      if (expected_reports.size() == 0) begin
        n_errors++;
        if (n_errors <= MAX_REPORTS)
          $error("result transaction arrived with no event pending");
        return;
      end
      want = expected_reports.pop_front();
      n_checked++;
      compare_field("pim_active", FIELD_BITS'(want.pim_active),
                    FIELD_BITS'(got.pim_active));
      compare_field("switch_event", FIELD_BITS'(want.sw), FIELD_BITS'(got.sw));
      compare_field("closed_batch_time", want.closed, got.closed);
      compare_field("wasted_valid", FIELD_BITS'(want.wasted_valid),
                    FIELD_BITS'(got.wasted_valid));
      compare_field("wasted_cycles", want.wasted, got.wasted);
    endfunction

    function int pending();
      return expected_reports.size();
    endfunction
  endclass

  // ---------------------------------------------------------------------
  // DUT signals, all inputs known from time zero
  // ---------------------------------------------------------------------
  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     cfg_wr_en = 1'b0;
  logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_wdata = '0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [MODE_BITS-1:0]     in_mode = '0;
  logic [FIELD_BITS-1:0]    in_cycle = '0;
  logic                     in_have_mem = 1'b0;
  logic                     in_have_pim = 1'b0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic                     out_pim_active;
  logic [SW_BITS-1:0]       out_switch_event;
  logic [FIELD_BITS-1:0]    out_closed_batch_time;
  logic                     out_wasted_valid;
  logic [FIELD_BITS-1:0]    out_wasted_cycles;

  switch_scoreboard sb = new();

  // Traffic shaping knobs, percent of cycles spent idle or stalled
  int   send_idle_pct = 0;
  int   stall_pct = 0;
  bit   hold_req = 1'b0;
  int   n_configs = 0;
  logic [FIELD_BITS-1:0] dram_now = '0;

  pim_mem_mode_switch_policy dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_wr_en            (cfg_wr_en),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_mode              (in_mode),
    .in_cycle             (in_cycle),
    .in_have_mem          (in_have_mem),
    .in_have_pim          (in_have_pim),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_pim_active       (out_pim_active),
    .out_switch_event     (out_switch_event),
    .out_closed_batch_time(out_closed_batch_time),
    .out_wasted_valid     (out_wasted_valid),
    .out_wasted_cycles    (out_wasted_cycles)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Watchdog: far beyond the slowest legal run (about a thousand transactions)
  initial begin
    #4000000;
    $display("TEST FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Result side: check every accepted transaction, then pick the next
  // ready level. A hold request turns into a long stall counted here.
  // ---------------------------------------------------------------------
  initial begin
    mode_report_t got;
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        got.pim_active   = out_pim_active;
        got.sw           = switch_t'(out_switch_event);
        got.closed       = out_closed_batch_time;
        got.wasted_valid = out_wasted_valid;
        got.wasted       = out_wasted_cycles;
        sb.check_report(got);
      end
      if (hold_req) begin
        hold_left = LONG_HOLD;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------

  // Offer one event and hold it until the block takes it
  task automatic send_event(logic [MODE_BITS-1:0] kind, logic [FIELD_BITS-1:0] now,
                            logic mem, logic pim);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_mode     <= kind;
    in_cycle    <= now;
    in_have_mem <= mem;
    in_have_pim <= pim;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.add_event(kind, now, mem, pim);
  endtask

  // Let every pending result come out, plus pipeline slack
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  // Registers change only with the block idle. Upper data bits of the
  // slowdown write are junk on purpose; only the low byte must count.
  task automatic configure(logic [MIN_BITS-1:0] min_req, logic [SLOW_BITS-1:0] slow);
    drain();
    write_reg(REG_MIN_PIM, min_req);
    write_reg(REG_SLOWDOWN, {8'($urandom), slow});
    cfg_wr_en <= 1'b0;
    n_configs++;
  endtask

  // Mostly a DRAM clock creeping forward; now and then a jump anywhere
  // in the 48-bit range or right up to the wrap point.
  task automatic random_event();
    int pick;
    logic [MODE_BITS-1:0] kind;
    pick = $urandom_range(0, 99);
    if (pick < 40) kind = EV_EVAL;
    else if (pick < 65) kind = EV_MEM_ISS;
    else if (pick < 95) kind = EV_PIM_ISS;
    else kind = EV_UNUSED;
    pick = $urandom_range(0, 99);
    if (pick < 2) dram_now = {16'($urandom), 32'($urandom)};
    else if (pick < 3) dram_now = CYC_MAX - $urandom_range(0, 50);
    else dram_now = dram_now + $urandom_range(0, 40);
    send_event(kind, dram_now, $urandom_range(0, 99) < 65, $urandom_range(0, 99) < 65);
  endtask

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    int mins[6];
    int slows[6];
    int p;
    int i;
    mins  = '{0, 3, 65535, 8, 1, 12};
    slows = '{0, 2, 1, 1, 255, 7};

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: start at reset config (min 8, slowdown 1)
    send_event(EV_UNUSED, 48'h1234_5678_9abc, 1'b1, 1'b1);  // no-op code
    send_event(EV_EVAL, '0, 1'b0, 1'b0);                    // nothing waits
    send_event(EV_MEM_ISS, 48'd10, 1'b0, 1'b0);
    send_event(EV_PIM_ISS, 48'd20, 1'b1, 1'b1);             // issue while in memory mode
    send_event(EV_EVAL, 48'd30, 1'b1, 1'b1);                // deadline passed -> PIM

    configure(16'd2, 8'd255);
    send_event(EV_PIM_ISS, CYC_MAX, 1'b1, 1'b1);            // begin already set
    send_event(EV_EVAL, 48'd40, 1'b1, 1'b1);                // min count met -> memory
    send_event(EV_MEM_ISS, 48'd50, 1'b0, 1'b0);
    send_event(EV_EVAL, 48'd100, 1'b1, 1'b1);               // inside budget, stay
    send_event(EV_EVAL, 48'd100, 1'b0, 1'b1);               // memory idle, early switch
    send_event(EV_PIM_ISS, CYC_MAX, 1'b1, 1'b1);            // batch begins at max
    send_event(EV_EVAL, 48'd5, 1'b1, 1'b1);                 // duration wraps
    send_event(EV_EVAL, 48'd7, 1'b1, 1'b0);                 // PIM queue empty -> memory
    send_event(EV_UNUSED, '0, 1'b0, 1'b0);
    send_event(EV_EVAL, CYC_MAX, 1'b0, 1'b1);               // closes batch begun at zero
    send_event(EV_PIM_ISS, 48'd1, 1'b0, 1'b1);
    send_event(EV_EVAL, 48'h8000_0000_0000, 1'b1, 1'b0);    // deadline clamps
    send_event(EV_EVAL, 48'd5, 1'b0, 1'b1);                 // huge wasted count
    send_event(EV_EVAL, CYC_MAX, 1'b1, 1'b1);               // no PIM issued, stay
    send_event(EV_EVAL, 48'd10, 1'b1, 1'b0);

    configure(16'd0, 8'd0);
    send_event(EV_EVAL, 48'd20, 1'b0, 1'b1);
    send_event(EV_EVAL, 48'd21, 1'b1, 1'b1);                // zero budget, deadline = now
    send_event(EV_EVAL, 48'd21, 1'b1, 1'b1);                // now == deadline, stay
    send_event(EV_EVAL, 48'd21, 1'b0, 1'b1);                // switch, nothing wasted

    // Random phases; the idle pattern rotates with the phase number
    for (p = 0; p < 6; p++) begin
      if (p == 5) configure(16'($urandom_range(1, 12)), 8'($urandom));
      else configure(16'(mins[p]), 8'(slows[p]));
      case (p % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 68; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 68; end
        default: begin send_idle_pct = 8; stall_pct = 8; end
      endcase
      // Phase 4: results blocked for a long while so the block backs up
      if (p == 4) hold_req = 1'b1;
      for (i = 0; i < 160; i++) random_event();
    end

    drain();
    $display("Checked %0d result transactions across %0d register settings.",
             sb.n_checked, n_configs + 1);
    $display("Saw %0d switches to memory mode, %0d to PIM mode, %0d of them early.",
             sb.n_to_mem, sb.n_to_pim, sb.n_wasted);
    if (sb.n_errors == 0 && sb.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
